@@ rtl/gbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

    localparam int IMG_COLS = 640;
    localparam int IMG_ROWS = 480;
    localparam int PIXELS   = IMG_COLS * IMG_ROWS;

    localparam int IDX_W  = 19;
    localparam int PIX_W  = 25;
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int VAL_W  = 8;
    localparam int FC_W   = 10;
    localparam int SUM_W  = 18;
    localparam int SQ_W   = 26;
    localparam int MEM_W  = SUM_W + SQ_W;
    localparam int DEV_W  = 27;
    localparam int VAR_W  = 15;

    localparam logic [FC_W-1:0]  FRAME_COUNT_RESET = FC_W'(1000);
    localparam logic [VAL_W-1:0] MEAN_MAX          = VAL_W'(255);
    localparam logic [VAR_W-1:0] VAR_MAX           = VAR_W'(16384);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic CMD_LEARN  = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [VAL_W-1:0] val;
        logic [FC_W-1:0]  nfr;
    } det_item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

`default_nettype wire

@@ rtl/gbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [gbs_pkg::IDX_W-1:0]     s_pixel_index,
    input  logic [gbs_pkg::VAL_W-1:0]     s_pixel_value,
    input  logic [gbs_pkg::FC_W-1:0]      frame_count,
    output gbs_pkg::det_item_t            push_item,
    output logic                          push_valid,
    input  logic                          push_ready
);

    localparam logic [gbs_pkg::ADDR_W-1:0] LAST_ADDR = gbs_pkg::ADDR_W'(gbs_pkg::PIXELS - 1);

    logic [gbs_pkg::MEM_W-1:0] mem [0:gbs_pkg::PIXELS-1];

    logic                          clr_busy_reg;
    logic [gbs_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic                          b_valid_reg;
    logic                          b_cmd_reg;
    logic                          b_inr_reg;
    logic [gbs_pkg::ADDR_W-1:0]    b_addr_reg;
    logic [gbs_pkg::VAL_W-1:0]     b_val_reg;
    logic [gbs_pkg::MEM_W-1:0]     rdata_reg;
    logic                          fw_valid_reg;
    logic [gbs_pkg::ADDR_W-1:0]    fw_addr_reg;
    logic [gbs_pkg::MEM_W-1:0]     fw_data_reg;
    logic [gbs_pkg::FC_W-1:0]      learned_reg;
    logic [gbs_pkg::FC_W-1:0]      learned_next;

    logic                          b_adv;
    logic                          accept;
    logic                          in_range;
    logic [gbs_pkg::ADDR_W-1:0]    in_addr;
    logic                          do_write;
    logic [gbs_pkg::MEM_W-1:0]     cur;
    logic [gbs_pkg::SUM_W-1:0]     sum_cur;
    logic [gbs_pkg::SQ_W-1:0]      sq_cur;
    logic [gbs_pkg::SUM_W-1:0]     sum_new;
    logic [gbs_pkg::SQ_W-1:0]      sq_new;
    logic [15:0]                   val_sq;

    assign in_range = {6'b0, s_pixel_index} < gbs_pkg::PIX_W'(gbs_pkg::PIXELS);
    assign in_addr  = gbs_pkg::ADDR_W'(s_pixel_index);

    assign b_adv   = !b_valid_reg || (b_cmd_reg == gbs_pkg::CMD_LEARN) || push_ready;
    assign s_ready = !clr_busy_reg && b_adv;
    assign accept  = s_valid && s_ready;

    // last write is not yet visible to a read issued on the same edge
    assign cur     = (fw_valid_reg && fw_addr_reg == b_addr_reg) ? fw_data_reg : rdata_reg;
    assign sum_cur = b_inr_reg ? cur[gbs_pkg::MEM_W-1:gbs_pkg::SQ_W] : '0;
    assign sq_cur  = b_inr_reg ? cur[gbs_pkg::SQ_W-1:0] : '0;
    assign val_sq  = 16'(b_val_reg) * 16'(b_val_reg);
    assign sum_new = sum_cur + gbs_pkg::SUM_W'(b_val_reg);
    assign sq_new  = sq_cur + gbs_pkg::SQ_W'(val_sq);

    assign do_write = b_valid_reg && (b_cmd_reg == gbs_pkg::CMD_LEARN) && b_inr_reg
                      && (learned_reg < frame_count);

    always_comb begin
        learned_next = learned_reg;
        if (do_write && b_addr_reg == LAST_ADDR) begin
            learned_next = learned_reg + 1'b1;
        end
    end

    assign push_valid     = b_valid_reg && (b_cmd_reg == gbs_pkg::CMD_DETECT);
    assign push_item.sum  = sum_cur;
    assign push_item.sq   = sq_cur;
    assign push_item.val  = b_val_reg;
    assign push_item.nfr  = learned_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (do_write) begin
            mem[b_addr_reg] <= {sum_new, sq_new};
        end
        if (accept && in_range) begin
            rdata_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
            learned_reg  <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (b_adv) begin
                b_valid_reg <= accept;
            end
            if (do_write) begin
                fw_valid_reg <= 1'b1;
            end
            learned_reg <= learned_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_cmd_reg  <= s_command;
            b_inr_reg  <= in_range;
            b_addr_reg <= in_addr;
            b_val_reg  <= s_pixel_value;
        end
        if (do_write) begin
            fw_addr_reg <= b_addr_reg;
            fw_data_reg <= {sum_new, sq_new};
        end
    end

    a_no_item_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !b_valid_reg)
        else $error("item in flight during clearing pass");

    a_frame_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(learned_reg)) |->
            $past(do_write && b_addr_reg == LAST_ADDR))
        else $error("learned frame count moved without last pixel learnt");

endmodule

`default_nettype wire

@@ rtl/gbs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbs_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gbs_pkg::det_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gbs_pkg::det_item_t    out_item
);

    gbs_pkg::det_item_t             slot [0:gbs_pkg::Q_DEPTH-1];
    logic [gbs_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [gbs_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [gbs_pkg::Q_CNT_W-1:0]    count_reg;
    logic [gbs_pkg::Q_CNT_W-1:0]    count_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = count_reg != gbs_pkg::Q_CNT_W'(gbs_pkg::Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= gbs_pkg::Q_CNT_W'(gbs_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/gbs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gbs_pkg::det_item_t            in_item,
    input  logic [gbs_pkg::FC_W-1:0]      divisor,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_foreground,
    output logic [gbs_pkg::VAL_W-1:0]     m_background_level,
    output logic [gbs_pkg::VAR_W-1:0]     m_variance_value
);

    localparam int N1 = gbs_pkg::SUM_W;
    localparam int N2 = gbs_pkg::DEV_W;

    logic adv;

    // mean divider, one quotient bit per stage
    logic [gbs_pkg::FC_W-1:0]  a_rem_reg [0:N1-1];
    logic [N1-1:0]             a_num_reg [0:N1-1];
    logic [N1-1:0]             a_quo_reg [0:N1-1];
    logic                      a_vld_reg [0:N1-1];
    logic [gbs_pkg::SUM_W-1:0] a_s_reg   [0:N1-1];
    logic [gbs_pkg::SQ_W-1:0]  a_q_reg   [0:N1-1];
    logic [gbs_pkg::VAL_W-1:0] a_v_reg   [0:N1-1];
    logic [gbs_pkg::FC_W-1:0]  a_n_reg   [0:N1-1];

    logic                      m_vld_reg;
    logic [gbs_pkg::VAL_W-1:0] m_mean_reg;
    logic [15:0]               m_mm_reg;
    logic [gbs_pkg::SUM_W-1:0] m_s_reg;
    logic [gbs_pkg::SQ_W-1:0]  m_q_reg;
    logic [gbs_pkg::VAL_W-1:0] m_v_reg;
    logic [gbs_pkg::FC_W-1:0]  m_n_reg;

    logic                      p_vld_reg;
    logic [25:0]               p_ms_reg;
    logic [25:0]               p_nmm_reg;
    logic [gbs_pkg::SQ_W-1:0]  p_q_reg;
    logic [gbs_pkg::VAL_W-1:0] p_v_reg;
    logic [gbs_pkg::VAL_W-1:0] p_mean_reg;

    logic                      d_vld_reg;
    logic [gbs_pkg::DEV_W-1:0] d_dev_reg;
    logic [gbs_pkg::VAL_W-1:0] d_v_reg;
    logic [gbs_pkg::VAL_W-1:0] d_mean_reg;

    // variance divider
    logic [gbs_pkg::FC_W-1:0]  b_rem_reg  [0:N2-1];
    logic [N2-1:0]             b_num_reg  [0:N2-1];
    logic [N2-1:0]             b_quo_reg  [0:N2-1];
    logic                      b_vld_reg  [0:N2-1];
    logic [gbs_pkg::VAL_W-1:0] b_v_reg    [0:N2-1];
    logic [gbs_pkg::VAL_W-1:0] b_mean_reg [0:N2-1];

    logic                      out_valid_reg;
    logic                      out_fg_reg;
    logic [gbs_pkg::VAL_W-1:0] out_level_reg;
    logic [gbs_pkg::VAR_W-1:0] out_var_reg;

    logic [gbs_pkg::VAL_W-1:0] mean_sat;
    logic [28:0]               dev_full;
    logic [gbs_pkg::VAR_W-1:0] var_sat;
    logic [gbs_pkg::VAL_W-1:0] diff;
    logic [16:0]               var17;
    logic [16:0]               thresh;

    assign adv      = !out_valid_reg || m_ready;
    assign in_ready = adv;

    genvar k;
    generate
        for (k = 0; k < N1; k++) begin : g_div1
            logic [gbs_pkg::FC_W-1:0] rem_in;
            logic [N1-1:0]            num_in;
            logic [N1-1:0]            quo_in;
            logic                     vld_in;
            logic [gbs_pkg::FC_W:0]   sh;
            logic                     ge;
            logic [gbs_pkg::FC_W:0]   diff_sh;
            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = in_item.sum;
                assign quo_in = '0;
                assign vld_in = in_valid;
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        a_s_reg[k] <= in_item.sum;
                        a_q_reg[k] <= in_item.sq;
                        a_v_reg[k] <= in_item.val;
                        a_n_reg[k] <= in_item.nfr;
                    end
                end
            end else begin : g_next
                assign rem_in = a_rem_reg[k-1];
                assign num_in = a_num_reg[k-1];
                assign quo_in = a_quo_reg[k-1];
                assign vld_in = a_vld_reg[k-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        a_s_reg[k] <= a_s_reg[k-1];
                        a_q_reg[k] <= a_q_reg[k-1];
                        a_v_reg[k] <= a_v_reg[k-1];
                        a_n_reg[k] <= a_n_reg[k-1];
                    end
                end
            end
            assign sh      = {rem_in, num_in[N1-1]};
            assign ge      = sh >= {1'b0, divisor};
            assign diff_sh = sh - {1'b0, divisor};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    a_vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    a_vld_reg[k] <= vld_in;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    a_rem_reg[k] <= ge ? diff_sh[gbs_pkg::FC_W-1:0] : sh[gbs_pkg::FC_W-1:0];
                    a_num_reg[k] <= {num_in[N1-2:0], 1'b0};
                    a_quo_reg[k] <= {quo_in[N1-2:0], ge};
                end
            end
        end
    endgenerate

    assign mean_sat = (a_quo_reg[N1-1] > N1'(gbs_pkg::MEAN_MAX)) ? gbs_pkg::MEAN_MAX
                                                               : a_quo_reg[N1-1][7:0];

    // deviation sum: sumsq - 2*mean*sum + n*mean^2, clamped at zero
    assign dev_full = {3'b0, p_q_reg} + {3'b0, p_nmm_reg} - {2'b0, p_ms_reg, 1'b0};

    generate
        for (k = 0; k < N2; k++) begin : g_div2
            logic [gbs_pkg::FC_W-1:0] rem_in;
            logic [N2-1:0]            num_in;
            logic [N2-1:0]            quo_in;
            logic                     vld_in;
            logic [gbs_pkg::FC_W:0]   sh;
            logic                     ge;
            logic [gbs_pkg::FC_W:0]   diff_sh;
            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = d_dev_reg;
                assign quo_in = '0;
                assign vld_in = d_vld_reg;
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        b_v_reg[k]    <= d_v_reg;
                        b_mean_reg[k] <= d_mean_reg;
                    end
                end
            end else begin : g_next
                assign rem_in = b_rem_reg[k-1];
                assign num_in = b_num_reg[k-1];
                assign quo_in = b_quo_reg[k-1];
                assign vld_in = b_vld_reg[k-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        b_v_reg[k]    <= b_v_reg[k-1];
                        b_mean_reg[k] <= b_mean_reg[k-1];
                    end
                end
            end
            assign sh      = {rem_in, num_in[N2-1]};
            assign ge      = sh >= {1'b0, divisor};
            assign diff_sh = sh - {1'b0, divisor};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    b_vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    b_vld_reg[k] <= vld_in;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    b_rem_reg[k] <= ge ? diff_sh[gbs_pkg::FC_W-1:0] : sh[gbs_pkg::FC_W-1:0];
                    b_num_reg[k] <= {num_in[N2-2:0], 1'b0};
                    b_quo_reg[k] <= {quo_in[N2-2:0], ge};
                end
            end
        end
    endgenerate

    assign var_sat = (b_quo_reg[N2-1] > N2'(gbs_pkg::VAR_MAX)) ? gbs_pkg::VAR_MAX
                                                              : b_quo_reg[N2-1][gbs_pkg::VAR_W-1:0];
    assign diff    = (b_v_reg[N2-1] > b_mean_reg[N2-1]) ? b_v_reg[N2-1] - b_mean_reg[N2-1]
                                                        : b_mean_reg[N2-1] - b_v_reg[N2-1];
    assign var17   = {2'b0, var_sat};
    assign thresh  = var17 + {var17[15:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg     <= a_vld_reg[N1-1];
            p_vld_reg     <= m_vld_reg;
            d_vld_reg     <= p_vld_reg;
            out_valid_reg <= b_vld_reg[N2-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_mean_reg    <= mean_sat;
            m_mm_reg      <= 16'(mean_sat) * 16'(mean_sat);
            m_s_reg       <= a_s_reg[N1-1];
            m_q_reg       <= a_q_reg[N1-1];
            m_v_reg       <= a_v_reg[N1-1];
            m_n_reg       <= a_n_reg[N1-1];

            p_ms_reg      <= 26'(m_mean_reg) * 26'(m_s_reg);
            p_nmm_reg     <= 26'(m_n_reg) * 26'(m_mm_reg);
            p_q_reg       <= m_q_reg;
            p_v_reg       <= m_v_reg;
            p_mean_reg    <= m_mean_reg;

            d_dev_reg     <= dev_full[28] ? '0 : dev_full[gbs_pkg::DEV_W-1:0];
            d_v_reg       <= p_v_reg;
            d_mean_reg    <= p_mean_reg;

            out_fg_reg    <= {9'b0, diff} > thresh;
            out_level_reg <= b_mean_reg[N2-1];
            out_var_reg   <= var_sat;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_foreground       = out_fg_reg;
    assign m_background_level = out_level_reg;
    assign m_variance_value   = out_var_reg;

endmodule

`default_nettype wire

@@ rtl/gaussian_background_subtractor_unit.sv @@
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------------
// input     | s_valid / s_ready   | s_command, s_pixel_index, s_pixel_value
// result    | m_valid / m_ready   | m_foreground, m_background_level, m_variance_value
// config    | cfg_wr_en           | cfg_wr_data (frame_count)
//
// One word per cycle in while s_ready is high; a detect word passes in order through
// the store read, 18-bit mean divider, products, deviation and 27-bit variance divider.
// After reset a clearing pass writes every store row once, with s_ready low.
// Learn words update the stores through a one-deep write-forward; detect words pass
// a 4-entry queue, so a stalled result side blocks learning only once the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_background_subtractor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gbs_pkg::FC_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [gbs_pkg::IDX_W-1:0]     s_pixel_index,
    input  logic [gbs_pkg::VAL_W-1:0]     s_pixel_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_foreground,
    output logic [gbs_pkg::VAL_W-1:0]     m_background_level,
    output logic [gbs_pkg::VAR_W-1:0]     m_variance_value
);

    logic [gbs_pkg::FC_W-1:0] frame_count_reg;
    logic [gbs_pkg::FC_W-1:0] divisor;
    gbs_pkg::det_item_t       push_item;
    gbs_pkg::det_item_t       pop_item;
    gbs_pkg::hs_t             push_hs;
    gbs_pkg::hs_t             pop_hs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= gbs_pkg::FRAME_COUNT_RESET;
        end else if (cfg_wr_en) begin
            frame_count_reg <= cfg_wr_data;
        end
    end

    // zero count divides by one
    assign divisor = (frame_count_reg == '0) ? gbs_pkg::FC_W'(1) : frame_count_reg;

    gbs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_pixel_index (s_pixel_index),
        .s_pixel_value (s_pixel_value),
        .frame_count   (frame_count_reg),
        .push_item     (push_item),
        .push_valid    (push_hs.valid),
        .push_ready    (push_hs.ready)
    );

    gbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_hs.valid),
        .in_ready  (push_hs.ready),
        .in_item   (push_item),
        .out_valid (pop_hs.valid),
        .out_ready (pop_hs.ready),
        .out_item  (pop_item)
    );

    gbs_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (pop_hs.valid),
        .in_ready           (pop_hs.ready),
        .in_item            (pop_item),
        .divisor            (divisor),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_foreground       (m_foreground),
        .m_background_level (m_background_level),
        .m_variance_value   (m_variance_value)
    );

endmodule

`default_nettype wire

@@ test/gaussian_background_subtractor_unit_test.sv @@
`timescale 1ns / 1ps

module gaussian_background_subtractor_unit_test;

    localparam int TAIL_CYCLES = 64;   // covers the detect path
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic                              cmd;
        logic [gbs_pkg::IDX_W-1:0]         idx;
        logic [gbs_pkg::VAL_W-1:0]         val;
        bit                                typed;
        logic                              fg;
        logic [gbs_pkg::VAL_W-1:0]         lvl;
        logic [gbs_pkg::VAR_W-1:0]         vari;
    } stim_row_t;

    typedef struct {
        logic                              fg;
        logic [gbs_pkg::VAL_W-1:0]         lvl;
        logic [gbs_pkg::VAR_W-1:0]         vari;
    } pixel_verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [gbs_pkg::FC_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = gbs_pkg::CMD_LEARN;
    logic [gbs_pkg::IDX_W-1:0] s_pixel_index = '0;
    logic [gbs_pkg::VAL_W-1:0] s_pixel_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_foreground;
    logic [gbs_pkg::VAL_W-1:0] m_background_level;
    logic [gbs_pkg::VAR_W-1:0] m_variance_value;

    gaussian_background_subtractor_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_pixel_index(s_pixel_index), .s_pixel_value(s_pixel_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_foreground(m_foreground),
        .m_background_level(m_background_level), .m_variance_value(m_variance_value)
    );

    // pixel model shadow
    bit [gbs_pkg::SUM_W-1:0] sum_mem [int unsigned];
    bit [gbs_pkg::SQ_W-1:0]  sq_mem [int unsigned];
    bit [gbs_pkg::FC_W-1:0]  frames_done;
    bit [gbs_pkg::FC_W-1:0]  frame_limit;

    pixel_verdict_t verdicts_due [$];
    int errors = 0;
    int idle_mode = 0;   // 0: sender light, receiver heavy; 1: swapped; 2: none
    int hold_trig = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end

    // receiver back-pressure
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (idle_mode)
                0: m_ready <= ($urandom_range(0, 99) >= 67);
                1: m_ready <= ($urandom_range(0, 99) >= 25);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        pixel_verdict_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected word fg=%0d lvl=%0d var=%0d", $time,
                         m_foreground, m_background_level, m_variance_value);
                errors++;
            end else begin
                exp_v = verdicts_due.pop_front();
                if (m_foreground !== exp_v.fg) begin
                    $display("%0t: foreground exp %0d got %0d", $time, exp_v.fg,
                             m_foreground);
                    errors++;
                end
                if (m_background_level !== exp_v.lvl) begin
                    $display("%0t: background_level exp %0d got %0d", $time, exp_v.lvl,
                             m_background_level);
                    errors++;
                end
                if (m_variance_value !== exp_v.vari) begin
                    $display("%0t: variance_value exp %0d got %0d", $time, exp_v.vari,
                             m_variance_value);
                    errors++;
                end
            end
        end
    end

    // updates the pixel model; returns 1 with the verdict for a detect word
    function automatic bit model_pixel(input logic cmd,
                                       input logic [gbs_pkg::IDX_W-1:0] idx,
                                       input logic [gbs_pkg::VAL_W-1:0] val,
                                       output pixel_verdict_t verdict);
        int unsigned a;
        longint s, q, n, dv, mean, dev, vr, diff, v;
        a = {13'b0, idx};
        v = longint'(val);
        s = 0;
        q = 0;
        if (a < gbs_pkg::PIXELS) begin
            if (sum_mem.exists(a)) s = longint'(sum_mem[a]);
            if (sq_mem.exists(a)) q = longint'(sq_mem[a]);
        end
        if (cmd == gbs_pkg::CMD_LEARN) begin
            if (a < gbs_pkg::PIXELS && frames_done < frame_limit) begin
                sum_mem[a] = gbs_pkg::SUM_W'(s + v);
                sq_mem[a] = gbs_pkg::SQ_W'(q + v * v);
                if (a == gbs_pkg::PIXELS - 1) frames_done = frames_done + 1'b1;
            end
            return 0;
        end
        n = longint'(frames_done);
        dv = (frame_limit == '0) ? 64'sd1 : longint'(frame_limit);
        mean = s / dv;
        if (mean > longint'(gbs_pkg::MEAN_MAX)) mean = longint'(gbs_pkg::MEAN_MAX);
        dev = q - 2 * mean * s + n * mean * mean;
        if (dev < 0) dev = 0;
        vr = dev / dv;
        if (vr > longint'(gbs_pkg::VAR_MAX)) vr = longint'(gbs_pkg::VAR_MAX);
        diff = (v > mean) ? v - mean : mean - v;
        verdict.fg = (diff > 3 * vr);
        verdict.lvl = gbs_pkg::VAL_W'(mean);
        verdict.vari = gbs_pkg::VAR_W'(vr);
        return 1;
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic push_pixel(input stim_row_t row);
        pixel_verdict_t v;
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 25 : (idle_mode == 1) ? 67 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= row.cmd;
        s_pixel_index <= row.idx;
        s_pixel_value <= row.val;
        do @(posedge aclk); while (!s_ready);
        if (model_pixel(row.cmd, row.idx, row.val, v)) begin
            if (row.typed) begin
                v.fg = row.fg;
                v.lvl = row.lvl;
                v.vari = row.vari;
            end
            verdicts_due.push_back(v);
        end
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frame_count(input logic [gbs_pkg::FC_W-1:0] fc);
        drain_and_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= fc;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_limit = fc;
    endtask

    task automatic random_phase(input int count, input int mode, input bit with_hold);
        stim_row_t r;
        int pick;
        idle_mode = mode;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) hold_trig <= hold_trig + 1;
            r.typed = 1'b0;
            r.cmd = ($urandom_range(0, 2) == 0) ? gbs_pkg::CMD_DETECT : gbs_pkg::CMD_LEARN;
            pick = $urandom_range(0, 19);
            case (pick)
                0: r.idx = gbs_pkg::IDX_W'($urandom);
                1: r.idx = gbs_pkg::IDX_W'(gbs_pkg::PIXELS - 1);
                2, 3, 4, 5: r.idx = gbs_pkg::IDX_W'(0);
                6, 7, 8, 9: r.idx = gbs_pkg::IDX_W'(7);
                10, 11, 12, 13: r.idx = gbs_pkg::IDX_W'(12345);
                default: r.idx = gbs_pkg::IDX_W'(gbs_pkg::PIXELS - 2);
            endcase
            r.val = ($urandom_range(0, 3) == 0) ? 8'd255
                                                : gbs_pkg::VAL_W'($urandom_range(0, 255));
            push_pixel(r);
        end
    endtask

    stim_row_t directed [0:15] = '{
        '{gbs_pkg::CMD_DETECT, 19'd0,      8'd0,   1'b1, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd0,      8'd255, 1'b1, 1'b1, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd524287, 8'd128, 1'b1, 1'b1, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd307199, 8'd1,   1'b1, 1'b1, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd7,      8'd255, 1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd7,      8'd255, 1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd307200, 8'd9,   1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd7,      8'd255, 1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd307200, 8'd0,   1'b1, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd0,      8'd0,   1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd0,      8'd0,   1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd12345,  8'd170, 1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd12345,  8'd85,  1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_LEARN,  19'd307199, 8'd255, 1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd307199, 8'd0,   1'b0, 1'b0, 8'd0, 15'd0},
        '{gbs_pkg::CMD_DETECT, 19'd7,      8'd0,   1'b0, 1'b0, 8'd0, 15'd0}
    };

    initial begin
        frames_done = '0;
        frame_limit = gbs_pkg::FRAME_COUNT_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_mode = 0;
        foreach (directed[i]) push_pixel(directed[i]);

        // frames_done is already 1 here, so a limit of 1 freezes learning
        write_frame_count(10'd1);
        random_phase(100, 0, 1'b0);
        write_frame_count(10'd0);
        random_phase(100, 1, 1'b0);
        write_frame_count(10'd1023);
        random_phase(450, 0, 1'b1);
        write_frame_count(10'd5);
        random_phase(150, 1, 1'b0);
        write_frame_count(10'd1000);
        random_phase(200, 2, 1'b1);

        drain_and_idle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/gbs_pkg.sv
rtl/gbs_front.sv
rtl/gbs_queue.sv
rtl/gbs_back.sv
rtl/gaussian_background_subtractor_unit.sv
test/gaussian_background_subtractor_unit_test.sv
